// ===== sv/uac_pkg.sv =====
// ----------------------------------------------------------------------------
// uac_pkg
// Shared sizes, control types and character codes of the unsigned to ASCII
// converter.
// ----------------------------------------------------------------------------
package uac_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_BITS = 4;
    localparam int STORE_BITS = MAX_DIGITS * DIGIT_BITS;
    localparam int HEX_ROOM   = MAX_DIGITS - 2;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_BITS  = 8;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_X    = 8'h78;
    localparam logic [CHAR_BITS-1:0] ASCII_A    = 8'h61;

    localparam logic [DIGIT_BITS-1:0] DEC_CORR_MIN = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DEC_CORR_ADD = 4'd3;
    localparam logic [DIGIT_BITS-1:0] DEC_RADIX    = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_SKIP,
        ST_PFX0,
        ST_PFX1,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CK_DIGIT,
        CK_ZERO,
        CK_X
    } char_kind_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic drop;
        logic hex;
    } sh_ctrl_t;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] top_digit;
        logic                  over;
    } sh_stat_t;

    typedef struct packed {
        logic                  load;
        logic                  last;
        char_kind_t            kind;
        logic [DIGIT_BITS-1:0] digit;
    } emit_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] wide;
        wide = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
        if (d < DEC_RADIX)
            return ASCII_ZERO + wide;
        else
            return ASCII_A + wide - {{(CHAR_BITS-DIGIT_BITS){1'b0}}, DEC_RADIX};
    endfunction

endpackage

// ===== sv/uac_digit_shifter.sv =====
// ----------------------------------------------------------------------------
// uac_digit_shifter
// Bit-serial binary to digit conversion: shift-add-3 for decimal, plain
// nibble shifting for hex; then shifts digits out most significant first.
// ----------------------------------------------------------------------------
module uac_digit_shifter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  uac_pkg::sh_ctrl_t             ctrl,
    input  logic [uac_pkg::VALUE_BITS-1:0] number,
    output uac_pkg::sh_stat_t             stat
);

    logic [uac_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [uac_pkg::STORE_BITS-1:0] store_reg, store_next;
    logic                           over_reg, over_next;
    logic [uac_pkg::STORE_BITS-1:0] corr;
    logic                           hex_high_nz;

    // add 3 to every decimal digit of five or more before the shift
    always_comb
    begin
        logic [uac_pkg::DIGIT_BITS-1:0] d;
        d = '0;
        for (int i = 0; i < uac_pkg::MAX_DIGITS; i++)
        begin
            d = store_reg[i*uac_pkg::DIGIT_BITS +: uac_pkg::DIGIT_BITS];
            if (!ctrl.hex && d >= uac_pkg::DEC_CORR_MIN)
                corr[i*uac_pkg::DIGIT_BITS +: uac_pkg::DIGIT_BITS] = d + uac_pkg::DEC_CORR_ADD;
            else
                corr[i*uac_pkg::DIGIT_BITS +: uac_pkg::DIGIT_BITS] = d;
        end
    end

    always_comb
    begin
        value_next = value_reg;
        store_next = store_reg;
        over_next  = over_reg;
        if (ctrl.load)
        begin
            value_next = number;
            store_next = '0;
            over_next  = 1'b0;
        end
        else if (ctrl.conv)
        begin
            store_next = {corr[uac_pkg::STORE_BITS-2:0], value_reg[uac_pkg::VALUE_BITS-1]};
            value_next = {value_reg[uac_pkg::VALUE_BITS-2:0], 1'b0};
            // any bit carried past the top digit means digits were dropped
            over_next  = over_reg | corr[uac_pkg::STORE_BITS-1];
        end
        else if (ctrl.drop)
        begin
            store_next = {store_reg[uac_pkg::STORE_BITS-uac_pkg::DIGIT_BITS-1:0],
                          {uac_pkg::DIGIT_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            over_reg  <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            over_reg  <= over_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    assign hex_high_nz = |store_reg[uac_pkg::STORE_BITS-1 : uac_pkg::HEX_ROOM*uac_pkg::DIGIT_BITS];

    assign stat.top_digit = store_reg[uac_pkg::STORE_BITS-1 -: uac_pkg::DIGIT_BITS];
    assign stat.over      = over_reg | (ctrl.hex & hex_high_nz);

endmodule

// ===== sv/uac_char_out.sv =====
// ----------------------------------------------------------------------------
// uac_char_out
// Output register of the character channel; maps digits and prefix
// characters to ASCII.
// ----------------------------------------------------------------------------
module uac_char_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  uac_pkg::emit_t               emit,
    output logic                         free,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [uac_pkg::CHAR_BITS-1:0] text_char,
    output logic                         last_char
);

    logic                         valid_reg, valid_next;
    logic [uac_pkg::CHAR_BITS-1:0] text_reg;
    logic                         last_reg;
    logic [uac_pkg::CHAR_BITS-1:0] code;

    always_comb
    begin
        unique case (emit.kind)
            uac_pkg::CK_ZERO:  code = uac_pkg::ASCII_ZERO;
            uac_pkg::CK_X:     code = uac_pkg::ASCII_X;
            uac_pkg::CK_DIGIT: code = uac_pkg::digit_char(emit.digit);
            default:           code = uac_pkg::ASCII_ZERO;
        endcase
    end

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        priority if (emit.load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            text_reg <= code;
            last_reg <= emit.last;
        end
    end

    assign out_valid = valid_reg;
    assign text_char = text_reg;
    assign last_char = last_reg;

endmodule

// ===== sv/unsigned_to_ascii_converter.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_converter
// Turns an unsigned value into decimal text, or into hex text after "0x",
// one ASCII character per transfer, most significant first.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  input   | in_valid / in_stall   | cmd (1), number (64)
//  output  | out_valid / out_stall | text_char (8), last_char (1)
//
//  One value passes through conversion (one bit per cycle through the digit
//  shift register), trimming to 18 digits in hex, skipping of leading zeros
//  down to the last digit, the "0x" prefix in hex, then its characters.
//  in_stall is high from the accepting edge until the last character is
//  in the output register; the next value can be taken while it waits
//  there. Output stalls hold the character sequencer.
//  Reset is asynchronous.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [uac_pkg::VALUE_BITS-1:0] number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [uac_pkg::CHAR_BITS-1:0]  text_char,
    output logic                          last_char
);

    uac_pkg::state_t   state_reg, state_next;
    logic              hex_reg, hex_next;
    logic [uac_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [uac_pkg::DIG_CNT_W-1:0] rem_reg, rem_next;
    logic              over_lat_reg, over_lat_next;
    logic [uac_pkg::DIG_CNT_W-1:0] room;
    logic              free;
    logic              in_accept;
    logic              top_zero;
    logic              rem_one;
    uac_pkg::sh_ctrl_t sh_ctrl;
    uac_pkg::sh_stat_t sh_stat;
    uac_pkg::emit_t    emit;

    assign in_stall  = (state_reg != uac_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign room      = hex_reg ? uac_pkg::DIG_CNT_W'(uac_pkg::HEX_ROOM)
                               : uac_pkg::DIG_CNT_W'(uac_pkg::MAX_DIGITS);
    assign top_zero  = (sh_stat.top_digit == '0);
    assign rem_one   = (rem_reg == uac_pkg::DIG_CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            uac_pkg::ST_IDLE:
                if (in_accept)
                    state_next = uac_pkg::ST_CONV;
            uac_pkg::ST_CONV:
                if (bit_cnt_reg == uac_pkg::BIT_CNT_W'(1))
                    state_next = uac_pkg::ST_TRIM;
            uac_pkg::ST_TRIM:
                if (rem_reg <= room)
                    state_next = uac_pkg::ST_SKIP;
            uac_pkg::ST_SKIP:
                if (over_lat_reg || !top_zero || rem_one)
                    state_next = hex_reg ? uac_pkg::ST_PFX0 : uac_pkg::ST_EMIT;
            uac_pkg::ST_PFX0:
                if (free)
                    state_next = uac_pkg::ST_PFX1;
            uac_pkg::ST_PFX1:
                if (free)
                    state_next = uac_pkg::ST_EMIT;
            uac_pkg::ST_EMIT:
                if (free && rem_one)
                    state_next = uac_pkg::ST_IDLE;
            default:
                state_next = uac_pkg::ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        hex_next      = hex_reg;
        bit_cnt_next  = bit_cnt_reg;
        rem_next      = rem_reg;
        over_lat_next = over_lat_reg;
        sh_ctrl.load  = 1'b0;
        sh_ctrl.conv  = 1'b0;
        sh_ctrl.drop  = 1'b0;
        sh_ctrl.hex   = hex_reg;
        emit.load     = 1'b0;
        emit.last     = 1'b0;
        emit.kind     = uac_pkg::CK_DIGIT;
        emit.digit    = sh_stat.top_digit;
        unique case (state_reg)
            uac_pkg::ST_IDLE:
                if (in_accept)
                begin
                    hex_next     = cmd;
                    bit_cnt_next = uac_pkg::BIT_CNT_W'(uac_pkg::VALUE_BITS);
                    rem_next     = uac_pkg::DIG_CNT_W'(uac_pkg::MAX_DIGITS);
                    sh_ctrl.load = 1'b1;
                end
            uac_pkg::ST_CONV:
            begin
                sh_ctrl.conv = 1'b1;
                bit_cnt_next = bit_cnt_reg - uac_pkg::BIT_CNT_W'(1);
            end
            uac_pkg::ST_TRIM:
            begin
                // sample overflow while the full digit register is intact
                if (rem_reg == uac_pkg::DIG_CNT_W'(uac_pkg::MAX_DIGITS))
                    over_lat_next = sh_stat.over;
                if (rem_reg > room)
                begin
                    sh_ctrl.drop = 1'b1;
                    rem_next     = rem_reg - uac_pkg::DIG_CNT_W'(1);
                end
            end
            uac_pkg::ST_SKIP:
                if (!over_lat_reg && top_zero && !rem_one)
                begin
                    sh_ctrl.drop = 1'b1;
                    rem_next     = rem_reg - uac_pkg::DIG_CNT_W'(1);
                end
            uac_pkg::ST_PFX0:
            begin
                emit.load = free;
                emit.kind = uac_pkg::CK_ZERO;
            end
            uac_pkg::ST_PFX1:
            begin
                emit.load = free;
                emit.kind = uac_pkg::CK_X;
            end
            uac_pkg::ST_EMIT:
                if (free)
                begin
                    emit.load    = 1'b1;
                    emit.last    = rem_one;
                    sh_ctrl.drop = 1'b1;
                    rem_next     = rem_reg - uac_pkg::DIG_CNT_W'(1);
                end
            default:
            begin
                hex_next = hex_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= uac_pkg::ST_IDLE;
            hex_reg      <= 1'b0;
            bit_cnt_reg  <= '0;
            rem_reg      <= '0;
            over_lat_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hex_reg      <= hex_next;
            bit_cnt_reg  <= bit_cnt_next;
            rem_reg      <= rem_next;
            over_lat_reg <= over_lat_next;
        end
    end

    uac_digit_shifter u_shifter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sh_ctrl),
        .number (number),
        .stat   (sh_stat)
    );

    uac_char_out u_char_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == uac_pkg::ST_CONV |-> bit_cnt_reg != '0)
        else $error("conversion running with empty bit count");

    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uac_pkg::ST_SKIP || state_reg == uac_pkg::ST_EMIT) |-> rem_reg != '0)
        else $error("digit sequencer has no digits left");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load && emit.last |=> state_reg == uac_pkg::ST_IDLE)
        else $error("last character loaded but sequencer still busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> (!out_valid || !out_stall))
        else $error("character loaded over a stalled transfer");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == uac_pkg::ST_CONV && bit_cnt_reg ==
            uac_pkg::BIT_CNT_W'(uac_pkg::VALUE_BITS))
        else $error("accepted value did not start conversion");

endmodule
